### src/stg_pkg.sv
// ----------------------------------------------------------------------------
// stg_pkg
// Shared widths, register indexes, reset values and status type for the
// sine tone generator.
// ----------------------------------------------------------------------------
package stg_pkg;

  // default sizes of the oscillator word and the sample counter
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 24;

  // fixed field widths
  localparam int COEF_W     = 16;
  localparam int GAIN_W     = 15;
  localparam int DURATION_W = 24;
  localparam int PERIOD_W   = 16;
  localparam int DAC_W      = 8;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 8;

  // Q1.15 rounding: add half an LSB, then drop the fraction
  localparam int ROUND_SHIFT = 15;
  localparam int ROUND_BIAS  = 16384;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_COS  = 3'd0,
    REG_ROT_SIN  = 3'd1,
    REG_GAIN     = 3'd2,
    REG_DURATION = 3'd3,
    REG_PERIOD   = 3'd4
  } stg_reg_t;

  // register reset values
  localparam logic signed [COEF_W-1:0] RST_ROT_COS  = 16'sd32767;
  localparam logic signed [COEF_W-1:0] RST_ROT_SIN  = 16'sd0;
  localparam logic [GAIN_W-1:0]        RST_GAIN     = 15'd32767;
  localparam logic [DURATION_W-1:0]    RST_DURATION = 24'd1;
  localparam logic [PERIOD_W-1:0]      RST_PERIOD   = 16'd1;

  // per-slot status from the sequencer
  typedef struct packed {
    logic valid;  // a tone sample is produced this slot
    logic last;   // final sample of the tone
  } stg_status_t;

endpackage

### src/stg_dac_map.sv
// ----------------------------------------------------------------------------
// stg_dac_map
// Scale the sine word by the gain and map it onto the unsigned 8-bit DAC
// range: floor((gain*sine + 2^F) * 255 / 2^(F+1)), F = SAMPLE_WIDTH + 14.
// ----------------------------------------------------------------------------
module stg_dac_map #(
  parameter int SAMPLE_WIDTH = stg_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic [stg_pkg::GAIN_W-1:0]    gain,
  input  logic signed [SAMPLE_WIDTH-1:0] sine,
  output logic [stg_pkg::DAC_W-1:0]     dac
);
  import stg_pkg::*;

  localparam int F      = SAMPLE_WIDTH + 14;
  localparam int PROD_W = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int SCL_W  = F + 1 + DAC_W;

  logic signed [GAIN_W:0]   gain_s;
  logic signed [PROD_W-1:0] prod;
  logic [F:0]               offset;
  logic [SCL_W-1:0]         scaled;

  // exact gain product, then lift to a nonnegative value
  assign gain_s = {1'b0, gain};
  assign prod   = gain_s * sine;
  assign offset = prod[F:0] + {1'b1, {F{1'b0}}};

  // times 255 as shift and subtract, keep the top byte
  assign scaled = {offset, {DAC_W{1'b0}}} - SCL_W'(offset);
  assign dac    = scaled[SCL_W-1:F+1];

endmodule

### src/stg_oscillator.sv
// ----------------------------------------------------------------------------
// stg_oscillator
// Quadrature sine/cosine pair, rotated once per played sample by the
// configured coefficients with Q1.15 rounding and saturation.
// ----------------------------------------------------------------------------
module stg_oscillator #(
  parameter int SAMPLE_WIDTH = stg_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           start,
  input  logic signed [stg_pkg::COEF_W-1:0] rot_cos,
  input  logic signed [stg_pkg::COEF_W-1:0] rot_sin,
  output logic signed [SAMPLE_WIDTH-1:0] sine_cur
);
  import stg_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int SUM_W  = SAMPLE_WIDTH + COEF_W + 1;
  localparam int RND_W  = SUM_W - ROUND_SHIFT;

  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [RND_W-1:0] R_MAX =
    {{(RND_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [RND_W-1:0] R_MIN =
    {{(RND_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] sine, cosine;
  logic signed [SAMPLE_WIDTH-1:0] cos_cur;
  logic signed [PROD_W-1:0]       p_sc, p_sr, p_cc, p_cr;
  logic signed [SUM_W-1:0]        sum_sin, sum_cos;
  logic signed [SAMPLE_WIDTH-1:0] sine_next, cosine_next;

  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [SUM_W-1:0] sum
  );
    logic signed [SUM_W-1:0] biased;
    logic signed [RND_W-1:0] r;
    biased = sum + SUM_W'(ROUND_BIAS);
    r      = RND_W'(biased >>> ROUND_SHIFT);
    if (r > R_MAX) begin
      return R_MAX[SAMPLE_WIDTH-1:0];
    end else if (r < R_MIN) begin
      return R_MIN[SAMPLE_WIDTH-1:0];
    end
    return r[SAMPLE_WIDTH-1:0];
  endfunction

  // a start slot plays from sine -1, cosine 0
  assign sine_cur = start ? S_MIN : sine;
  assign cos_cur  = start ? '0 : cosine;

  // rotate: nsin = s*rc + rs*c, ncos = c*rc - s*rs
  assign p_sc    = sine_cur * rot_cos;
  assign p_sr    = sine_cur * rot_sin;
  assign p_cc    = cos_cur * rot_cos;
  assign p_cr    = cos_cur * rot_sin;
  assign sum_sin = SUM_W'(p_sc) + SUM_W'(p_cr);
  assign sum_cos = SUM_W'(p_cc) - SUM_W'(p_sr);

  assign sine_next   = round_sat(sum_sin);
  assign cosine_next = round_sat(sum_cos);

  // hold the pair except on a played sample
  always_ff @(posedge clk) begin
    if (rst) begin
      sine   <= S_MIN;
      cosine <= '0;
    end else if (advance) begin
      sine   <= sine_next;
      cosine <= cosine_next;
    end
  end

endmodule

### src/stg_sequencer.sv
// ----------------------------------------------------------------------------
// stg_sequencer
// Sample and period counters: main phase for the tone length, then a tail
// that runs to the end of the current period and flags the last sample.
// ----------------------------------------------------------------------------
module stg_sequencer #(
  parameter int COUNT_WIDTH = stg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             start,
  input  logic [stg_pkg::DURATION_W-1:0]   duration,
  input  logic [stg_pkg::PERIOD_W-1:0]     period,
  output stg_pkg::stg_status_t             status
);
  import stg_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > DURATION_W) ? COUNT_WIDTH : DURATION_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic                   active, in_tail;
  logic [COUNT_WIDTH-1:0] sample_count;
  logic [PERIOD_W-1:0]    period_count;

  logic                   eff_active, eff_tail;
  logic [COUNT_WIDTH-1:0] eff_sc, sc_inc;
  logic [PERIOD_W-1:0]    eff_pc;
  logic [PERIOD_W:0]      pc_inc;
  logic                   wrap;

  logic                   active_next, tail_next, last;
  logic [COUNT_WIDTH-1:0] sc_next;
  logic [PERIOD_W-1:0]    pc_next;

  // a start slot begins from cleared counters
  assign eff_active = start | active;
  assign eff_tail   = start ? 1'b0 : in_tail;
  assign eff_sc     = start ? '0 : sample_count;
  assign eff_pc     = start ? '0 : period_count;

  // saturating sample count, period count with room for the compare
  assign sc_inc = (eff_sc == COUNT_MAX) ? eff_sc : eff_sc + 1'b1;
  assign pc_inc = {1'b0, eff_pc} + 1'b1;
  assign wrap   = pc_inc >= {1'b0, period};

  // advance one sample
  always_comb begin
    active_next = eff_active;
    tail_next   = eff_tail;
    sc_next     = eff_sc;
    pc_next     = pc_inc[PERIOD_W-1:0];
    last        = 1'b0;
    if (!eff_tail) begin
      sc_next   = sc_inc;
      if (wrap) begin
        pc_next = '0;
      end
      tail_next = (CMP_W'(sc_inc) >= CMP_W'(duration)) || (sc_inc == COUNT_MAX);
    end else if (wrap) begin
      last        = 1'b1;
      active_next = 1'b0;
      tail_next   = 1'b0;
    end
  end

  assign status.valid = eff_active;
  assign status.last  = eff_active & last;

  // commit on each played sample
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      in_tail      <= 1'b0;
      sample_count <= '0;
      period_count <= '0;
    end else if (step && eff_active) begin
      active       <= active_next;
      in_tail      <= tail_next;
      sample_count <= sc_next;
      period_count <= pc_next;
    end
  end

  a_tail_in_tone: assert property (@(posedge clk) disable iff (rst)
    in_tail |-> active)
    else $error("tail phase outside an active tone");

  a_last_ends_tone: assert property (@(posedge clk) disable iff (rst)
    step && status.last |=> !active)
    else $error("tone still active after its last sample");

  a_tail_on_step: assert property (@(posedge clk) disable iff (rst)
    $rose(in_tail) |-> $past(step))
    else $error("tail phase entered without a slot");

endmodule

### src/sine_tone_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_generator
// Recursive quadrature sine oscillator feeding an 8-bit unsigned DAC, one
// sample word per input slot word.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata[0] start_req
//  m_*      out  m_tvalid/m_tready  m_tdata[7:0] dac_value, m_tuser[0]
//                                   sample_valid, m_tlast last_sample
//  cfg_*    in   cfg_we             cfg_index register, cfg_data value
//
//  One word per cycle while s_tready is high; the result sits in the output
//  register in the cycle after its slot word is taken. The sine/cosine
//  rotation (four 16x16 products and two sums per cycle) closes on itself.
//  Reset presets registers, oscillator and counters; no clearing pass.
//  s_tready drops only while the output register is full and m_tready low.
// ----------------------------------------------------------------------------
module sine_tone_generator #(
  parameter int SAMPLE_WIDTH = stg_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = stg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [stg_pkg::IN_DATA_W-1:0]     s_tdata,   // [0] start_req
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stg_pkg::DAC_W-1:0]         m_tdata,   // [7:0] dac_value
  output logic [0:0]                        m_tuser,   // [0] sample_valid
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [stg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import stg_pkg::*;

  logic signed [COEF_W-1:0] rot_cos, rot_sin;
  logic [GAIN_W-1:0]        gain;
  logic [DURATION_W-1:0]    duration;
  logic [PERIOD_W-1:0]      period;

  logic                           step, start;
  stg_status_t                    status;
  logic signed [SAMPLE_WIDTH-1:0] sine_cur;
  logic [DAC_W-1:0]               dac;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cos  <= RST_ROT_COS;
      rot_sin  <= RST_ROT_SIN;
      gain     <= RST_GAIN;
      duration <= RST_DURATION;
      period   <= RST_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROT_COS:  rot_cos  <= cfg_data[COEF_W-1:0];
        REG_ROT_SIN:  rot_sin  <= cfg_data[COEF_W-1:0];
        REG_GAIN:     gain     <= cfg_data[GAIN_W-1:0];
        REG_DURATION: duration <= cfg_data[DURATION_W-1:0];
        REG_PERIOD:   period   <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // take a slot word whenever the output register frees up
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;
  assign start    = s_tdata[0];

  stg_sequencer #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .start    (start),
    .duration (duration),
    .period   (period),
    .status   (status)
  );

  stg_oscillator #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_osc (
    .clk      (clk),
    .rst      (rst),
    .advance  (step && status.valid),
    .start    (start),
    .rot_cos  (rot_cos),
    .rot_sin  (rot_sin),
    .sine_cur (sine_cur)
  );

  stg_dac_map #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dac (
    .gain (gain),
    .sine (sine_cur),
    .dac  (dac)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata    <= status.valid ? dac : '0;
      m_tuser[0] <= status.valid;
      m_tlast    <= status.last;
    end
  end

  a_last_is_sample: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("last flag on a slot without a sample");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("nonzero dac word on an empty slot");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("accepted slot word produced no result");

endmodule

### sim/tb_sine_tone_generator.sv
// ----------------------------------------------------------------------------
// tb_sine_tone_generator
// Self-checking bench for the sine tone generator. A predictor inside the
// bench tracks the oscillator, the sample and period counters and the
// register file, so every slot word yields one expected DAC word. The bench
// plays directed tones at the register extremes, then random tone settings
// with well-formed tone sequences, restarts and noise. Gaps fall at random
// on both stream sides, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module tb_sine_tone_generator;
  import stg_pkg::*;

  localparam int SINK_HOLD      = 300;   // long receiver hold-off, cycles
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake or register write
  localparam int DRAIN_CYCLES   = 4;     // settle time past the last result
  localparam int REPORT_MAX     = 10;
  localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_FULL = '1;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [DAC_W-1:0]      m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // one output word: dac_value, sample_valid, last_sample
  typedef struct packed {
    logic [DAC_W-1:0] dac;
    logic             valid;
    logic             last;
  } dac_word_t;

  // Predicts the DAC word for each slot and matches it against the output.
  class tone_book;
    logic signed [COEF_W-1:0]     rot_cos;
    logic signed [COEF_W-1:0]     rot_sin;
    logic [GAIN_W-1:0]            gain;
    logic [DURATION_W-1:0]        duration;
    logic [PERIOD_W-1:0]          period;
    logic signed [15:0]           sine;
    logic signed [15:0]           cosine;
    logic [COUNT_WIDTH_DEF-1:0]   sample_count;
    int                           period_count;
    bit                           in_tail;
    bit                           active;
    dac_word_t                    dac_expected[$];
    int unsigned                  fails;

    function new();
      rot_cos      = RST_ROT_COS;
      rot_sin      = RST_ROT_SIN;
      gain         = RST_GAIN;
      duration     = RST_DURATION;
      period       = RST_PERIOD;
      sine         = -16'sd32768;
      cosine       = 16'sd0;
      sample_count = '0;
      period_count = 0;
      in_tail      = 1'b0;
      active       = 1'b0;
      fails        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ROT_COS:  rot_cos  = val[COEF_W-1:0];
        REG_ROT_SIN:  rot_sin  = val[COEF_W-1:0];
        REG_GAIN:     gain     = val[GAIN_W-1:0];
        REG_DURATION: duration = val[DURATION_W-1:0];
        REG_PERIOD:   period   = val[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    // Q1.15 product sum: round half up, saturate to the sample range
    function logic signed [15:0] round_sat(longint acc);
      longint r;
      r = (acc + ROUND_BIAS) >>> ROUND_SHIFT;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
    endfunction

    function void take_slot(bit start_req);
      dac_word_t w;
      longint    s, c, rc, rs, p;
      w = '0;
      // restart the oscillator and counters on a start word
      if (start_req) begin
        sine         = -16'sd32768;
        cosine       = 16'sd0;
        sample_count = '0;
        period_count = 0;
        in_tail      = 1'b0;
        active       = 1'b1;
      end
      if (active) begin
        s  = longint'(sine);
        c  = longint'(cosine);
        rc = longint'(rot_cos);
        rs = longint'(rot_sin);
        p  = longint'(gain) * s + (longint'(1) << 30);
        w.dac = 8'((p * 255) >>> 31);
        w.valid = 1'b1;
        // rotate the quadrature pair
        sine   = round_sat(s * rc + rs * c);
        cosine = round_sat(c * rc - s * rs);
        if (!in_tail) begin
          if (sample_count != COUNT_FULL) sample_count++;
          period_count++;
          if (period_count >= int'(period)) period_count = 0;
          if (sample_count >= duration || sample_count == COUNT_FULL) in_tail = 1'b1;
        end else begin
          // tail: finish the current period, then flag the last word
          period_count++;
          if (period_count >= int'(period)) begin
            period_count = period_count & 16'hFFFF;
            w.last  = 1'b1;
            active  = 1'b0;
            in_tail = 1'b0;
          end
        end
      end
      dac_expected.push_back(w);
    endfunction

    function void match_sample(logic [DAC_W-1:0] dac, logic valid, logic last);
      dac_word_t w;
      if (dac_expected.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("unexpected word: dac %0d valid %0b last %0b", dac, valid, last);
      end else begin
        w = dac_expected.pop_front();
        if (w.dac !== dac || w.valid !== valid || w.last !== last) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display({"mismatch: expected dac %0d valid %0b last %0b, ",
                      "got dac %0d valid %0b last %0b"},
                     w.dac, w.valid, w.last, dac, valid, last);
        end
      end
    endfunction

    function int pending();
      return dac_expected.size();
    endfunction
  endclass

  tone_book book;
  bit       steady_flow = 1'b0;   // no gaps on either side
  bit       hold_sink   = 1'b0;   // request one long receiver hold-off
  int       tone_span   = 2;      // rough slot count of one full tone
  int       idle_cycles = 0;

  sine_tone_generator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [0] start_req
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [7:0] dac_value
    .m_tuser   (m_tuser),    // [0] sample_valid
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady_flow || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // sample handshakes and register writes at each rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) book.match_sample(m_tdata, m_tuser[0], m_tlast);
      if (s_tvalid && s_tready) book.take_slot(s_tdata[0]);
      if (cfg_we) book.write_reg(cfg_index, cfg_data);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // end the run when nothing moves for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL sine_tone_generator");
    $finish;
  end

  // receiver: random ready gaps, steady stretches and one long hold-off
  initial begin
    int n;
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
        hold_sink = 1'b0;
      end else if (steady_flow) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // offer one slot word and hold it until taken
  task automatic send_slot(bit start_req);
    int n;
    n = pick_gap();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-1){1'b0}}, start_req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // drop valid and wait until every expected word has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(stg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_tone(logic signed [COEF_W-1:0] rc, logic signed [COEF_W-1:0] rs,
                          logic [GAIN_W-1:0] g, logic [DURATION_W-1:0] d,
                          logic [PERIOD_W-1:0] p);
    cfg_write(REG_ROT_COS,  {8'h00, rc});
    cfg_write(REG_ROT_SIN,  {8'h00, rs});
    cfg_write(REG_GAIN,     {9'h000, g});
    cfg_write(REG_DURATION, d);
    cfg_write(REG_PERIOD,   {8'h00, p});
    cfg_we <= 1'b0;
    tone_span = ((d > 60) ? 60 : int'(d)) + ((p > 60) ? 60 : int'(p)) + 1;
  endtask

  // random coefficients, either a real tone or arbitrary bits
  task automatic pick_random_tone();
    real                      angle;
    logic signed [COEF_W-1:0] rc, rs;
    logic [DURATION_W-1:0]    d;
    logic [PERIOD_W-1:0]      p;
    if ($urandom_range(2) == 0) begin
      rc = 16'($urandom);
      rs = 16'($urandom);
    end else begin
      angle = 6.283185307 * $urandom_range(1, 3999) / 8000.0;
      rc = 16'($rtoi(32767.0 * $cos(angle)));
      rs = 16'($rtoi(32767.0 * $sin(angle)));
    end
    d = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 30));
    p = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    set_tone(rc, rs, 15'($urandom), d, p);
  endtask

  // mostly full tones, some cut short by a restart, a little noise
  task automatic play_tones(int n);
    int sent, k, r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      send_slot(1'b1);
      sent++;
      if (r < 75) k = tone_span + $urandom_range(0, 3);
      else if (r < 92) k = $urandom_range(0, tone_span);
      else k = 0;
      // keep the phase near its word budget
      if (k > n - sent) k = n - sent;
      repeat (k) begin
        send_slot(1'b0);
        sent++;
      end
      if (r >= 92) begin
        repeat ($urandom_range(1, 6)) begin
          send_slot(1'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    book      = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: inactive slots, a two-word tone, restart while active
    send_slot(1'b0);
    send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b0);
    send_slot(1'b1);
    send_slot(1'b1);
    send_slot(1'b0);
    settle();

    // most negative coefficients, zero gain, zero duration and period
    set_tone(-16'sd32768, -16'sd32768, 15'd0, 24'd0, 16'd0);
    send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b0);
    send_slot(1'b1);
    send_slot(1'b0);
    settle();

    // full-scale coefficients and gain, longest duration and period
    set_tone(16'sd32767, 16'sd32767, 15'h7FFF, 24'hFFFFFF, 16'hFFFF);
    send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b0);
    send_slot(1'b0);
    send_slot(1'b1);
    send_slot(1'b0);
    settle();

    // main phase ends as the period wraps: tail plays a full period
    set_tone(16'sd32138, 16'sd6393, 15'd16384, 24'd4, 16'd2);
    send_slot(1'b1);
    repeat (8) send_slot(1'b0);
    settle();

    // random settings; one long output stall, some stretches without gaps
    for (int ph = 0; ph < 10; ph++) begin
      pick_random_tone();
      steady_flow = (ph % 4 == 3);
      if (ph == 2) hold_sink = 1'b1;
      play_tones(80);
      settle();
    end
    steady_flow = 1'b0;

    if (book.pending() != 0)
      $display("%0d expected words never arrived", book.pending());
    if (book.fails == 0 && book.pending() == 0)
      $display("PASS sine_tone_generator");
    else
      $display("FAIL sine_tone_generator");
    $finish;
  end

endmodule
